// ===== hdl/metap_pkg.sv =====
// Shared types, constants and taper table functions for the mask edge taper block.
package metap_pkg;

    localparam int MAX_HEIGHT    = 1024;
    localparam int ROW_W         = 11;
    localparam int DRAIN_CYCLES  = 5;
    localparam logic [63:0] ONE_Q30    = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [32:0] ONE_Q24    = 33'd16777216;

    // register indexes on the config port
    localparam logic [2:0] REG_TAPER_MODE   = 3'd0;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PITCH_X      = 3'd3;
    localparam logic [2:0] REG_PITCH_Y      = 3'd4;
    localparam logic [2:0] REG_HALF_X       = 3'd5;
    localparam logic [2:0] REG_HALF_Y       = 3'd6;

    localparam logic [1:0] MODE_C1 = 2'd1;
    localparam logic [1:0] MODE_C2 = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_ROM,
        S_MUL,
        S_DONE
    } state_t;

    // Integer square root, bit pair at a time.
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] nn;
        res = '0;
        bt  = 64'h1 << 62;
        nn  = n;
        for (int i = 0; i < 32; i++)
        begin
            if (bt > nn)
                bt = bt >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bt != 0)
            begin
                if (nn >= res + bt)
                begin
                    nn  = nn - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                    res = res >> 1;
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // Taylor sine over one quadrant, Q.30 in and out.
    function automatic longint sin_quadrant(input logic [63:0] phi);
        logic [63:0] p2;
        logic [63:0] term;
        longint      sum;
        p2   = (phi * phi) >> 30;
        term = phi;
        sum  = longint'(phi);
        for (int n = 1; n <= 9; n++)
        begin
            term = ((term * p2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        return sum;
    endfunction

    // Sine of an angle given in 2^-24 turns, quadrant folded.
    function automatic longint sin_turns(input logic [31:0] t);
        logic [31:0] tt;
        logic [1:0]  q;
        logic [31:0] r;
        longint      s;
        tt = t & 32'hFF_FFFF;
        q  = tt[23:22];
        r  = tt & 32'h3F_FFFF;
        if (q[0])
            r = 32'h40_0000 - r;
        s = sin_quadrant((64'(r) * TWO_PI_Q30) >> 24);
        return q[1] ? -s : s;
    endfunction

    function automatic logic [15:0] to_q15(input longint f);
        longint g;
        logic [63:0] u;
        g = f;
        if (g < 0)
            g = 0;
        if (g > longint'(ONE_Q30))
            g = longint'(ONE_Q30);
        u = 64'(g);
        return u[30:15];
    endfunction

    // Taper value for table entry k of a 2^lg entry table, Q1.15.
    function automatic logic [15:0] taper_entry(input int k, input int lg, input logic c2);
        logic [63:0] x64;
        logic [31:0] x24;
        longint      x30;
        longint      s;
        longint      c;
        logic [63:0] s_abs;
        longint      mag;
        x64   = isqrt64(64'(k) << (48 - lg));
        x24   = x64[31:0];
        x30   = longint'(x24) <<< 6;
        s     = sin_turns(x24);
        s_abs = (s < 0) ? 64'(-s) : 64'(s);
        mag   = longint'((s_abs << 30) / TWO_PI_Q30);
        c     = sin_turns((x24 >> 1) + 32'h40_0000);
        if (c2)
            return to_q15((longint'(ONE_Q30) - c) >>> 1);
        return to_q15((s >= 0) ? (x30 - mag) : (x30 + mag));
    endfunction

endpackage

// ===== hdl/metap_cell.sv =====
// Distance cell: scales one window offset by its pitch, squares it and adds to the running sum.
module metap_cell #(
    parameter int OW = 4,
    parameter int AW = 41
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [OW-1:0] offset,
    input  logic [15:0]   pitch,
    input  logic [OW-1:0] aux_in,
    input  logic [AW-1:0] acc_in,
    output logic          out_valid,
    output logic [OW-1:0] aux_out,
    output logic [AW-1:0] acc_out
);
    localparam int PDW = OW + 16;

    logic           v1_reg;
    logic           v2_reg;
    logic [PDW-1:0] p_reg;
    logic [AW-1:0]  acc1_reg;
    logic [AW-1:0]  acc2_reg;
    logic [OW-1:0]  aux1_reg;
    logic [OW-1:0]  aux2_reg;
    logic [2*PDW-1:0] sq;

    assign sq = p_reg * p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= {16'b0, offset} * {{OW{1'b0}}, pitch};
        acc1_reg <= acc_in;
        aux1_reg <= aux_in;
        acc2_reg <= AW'(sq) + acc1_reg;
        aux2_reg <= aux1_reg;
    end

    assign out_valid = v2_reg;
    assign aux_out   = aux2_reg;
    assign acc_out   = acc2_reg;

endmodule

// ===== hdl/mask_edge_taper_apodizer.sv =====
// Top level of the mask edge taper: row stores, window scan sequencer, taper table and output.
//
// Mask pixels enter in raster order and leave delayed by half_window_y rows and
// half_window_x columns. Each positive pixel, in taper modes, is scaled by a C1 or C2
// taper of its normalized squared distance to the nearest non-positive pixel inside
// the search window. Settings are latched at the first pixel of a frame. An item that
// releases a pixel reads the row store once per window position; each read feeds a
// chain of two distance cells and a min register, followed by the taper table read
// and one multiply. Pass-through pixels skip the window scan, and items that release
// nothing leave the input ready for the next item. A finished item waits in the output
// register while the next item is accepted. Flush items (tuser high) drain the pixels
// held after a frame's last pixel. The row stores need no clearing: only pixels of the
// current frame are read.
module mask_edge_taper_apodizer #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HALF_WINDOW = 8,
    parameter int TAPER_ROM_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] mask_value
    input  logic        s_tuser,   // flush
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] apodized_value, [25:16] pixel_column,
                                   // [35:26] pixel_row, [39:36] zero
    output logic        m_tlast,   // last_of_frame
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import metap_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int OW  = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SR  = 2 * MAX_HALF_WINDOW + 2;
    localparam int SW  = $clog2(SR);
    localparam int PW  = $clog2(MAX_HALF_WINDOW * MAX_WIDTH + MAX_HALF_WINDOW + 2);
    localparam int LG  = $clog2(TAPER_ROM_DEPTH);
    localparam int AW  = 2 * (OW + 16) + 1;
    localparam int DEPTH = SR << CW;

    typedef logic [15:0] rom_t [TAPER_ROM_DEPTH];

    function automatic rom_t build_rom(input logic c2);
        rom_t r;
        for (int k = 0; k < TAPER_ROM_DEPTH; k++)
            r[k] = taper_entry(k, LG, c2);
        return r;
    endfunction

    localparam rom_t ROM_C1 = build_rom(1'b0);
    localparam rom_t ROM_C2 = build_rom(1'b1);

    // ---- configuration registers
    logic [1:0]  taper_mode_reg;
    logic [10:0] frame_width_reg;
    logic [10:0] frame_height_reg;
    logic [15:0] pitch_x_reg;
    logic [15:0] pitch_y_reg;
    logic [3:0]  half_x_reg;
    logic [3:0]  half_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taper_mode_reg   <= 2'd0;
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 11'd1024;
            pitch_x_reg      <= 16'd4096;
            pitch_y_reg      <= 16'd4096;
            half_x_reg       <= 4'd1;
            half_y_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAPER_MODE:   taper_mode_reg   <= cfg_data[1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[10:0];
                REG_PITCH_X:      pitch_x_reg      <= cfg_data;
                REG_PITCH_Y:      pitch_y_reg      <= cfg_data;
                REG_HALF_X:       half_x_reg       <= cfg_data[3:0];
                REG_HALF_Y:       half_y_reg       <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // ---- settings for a new frame, clamped
    logic [31:0]    w32, h32, hx32, hy32, dly32;
    logic [WW-1:0]  new_w;
    logic [ROW_W-1:0] new_h;
    logic [OW-1:0]  new_hx, new_hy;
    logic [PW-1:0]  new_delay;

    always_comb
    begin
        w32 = (frame_width_reg == 11'd0) ? 32'd1 :
              ((32'(frame_width_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(frame_width_reg));
        h32 = (frame_height_reg == 11'd0) ? 32'd1 :
              ((32'(frame_height_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                          : 32'(frame_height_reg));
        hx32 = (32'(half_x_reg) > 32'(MAX_HALF_WINDOW)) ? 32'(MAX_HALF_WINDOW) : 32'(half_x_reg);
        hy32 = (32'(half_y_reg) > 32'(MAX_HALF_WINDOW)) ? 32'(MAX_HALF_WINDOW) : 32'(half_y_reg);
        if (hx32 > w32 - 32'd1)
            hx32 = w32 - 32'd1;
        if (hy32 > h32 - 32'd1)
            hy32 = h32 - 32'd1;
        dly32     = hy32 * w32 + hx32;
        new_w     = w32[WW-1:0];
        new_h     = h32[ROW_W-1:0];
        new_hx    = hx32[OW-1:0];
        new_hy    = hy32[OW-1:0];
        new_delay = dly32[PW-1:0];
    end

    // ---- latched frame settings
    logic [1:0]       lat_mode_reg;
    logic [WW-1:0]    lat_w_reg;
    logic [ROW_W-1:0] lat_h_reg;
    logic [15:0]      lat_px_reg, lat_py_reg;
    logic [OW-1:0]    lat_hx_reg, lat_hy_reg;
    logic [PW-1:0]    lat_delay_reg;

    // ---- stream position
    state_t           state_reg, state_next;
    logic [CW-1:0]    wcol_reg, ecol_reg;
    logic [ROW_W-1:0] wrow_reg, erow_reg;
    logic [SW-1:0]    wslot_reg, eslot_reg;
    logic [PW-1:0]    pend_reg;

    logic             accept, idle, latch_now, writes_done, do_write, emit;
    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [PW-1:0]    eff_delay;
    logic [31:0]      wcol_inc;

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign idle        = (wrow_reg == '0) && (wcol_reg == '0);
    assign latch_now   = accept && idle && !s_tuser;
    assign eff_w       = latch_now ? new_w : lat_w_reg;
    assign eff_h       = latch_now ? new_h : lat_h_reg;
    assign eff_delay   = latch_now ? new_delay : lat_delay_reg;
    assign writes_done = !idle && (wrow_reg >= eff_h);
    assign do_write    = accept && !s_tuser && !writes_done;
    assign emit        = do_write ? (32'(pend_reg) + 32'd1 > 32'(eff_delay))
                                  : (accept && writes_done);
    assign wcol_inc    = 32'(wcol_reg) + 32'd1;

    // ---- row stores
    logic [15:0] value_mem [DEPTH];
    logic        np_mem    [DEPTH];
    logic signed [15:0] val_q_reg;
    logic        np_q_reg;
    logic [CW-1:0] scan_c_reg;
    logic [SW-1:0] scan_slot_reg;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            value_mem[{wslot_reg, wcol_reg}] <= s_tdata;
            np_mem[{wslot_reg, wcol_reg}]    <= (s_tdata == 16'd0) || s_tdata[15];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
            val_q_reg <= value_mem[{eslot_reg, ecol_reg}];
        np_q_reg <= np_mem[{scan_slot_reg, scan_c_reg}];
    end

    // ---- window bounds of the pixel being emitted
    logic [ROW_W-1:0] r0, r1, scan_r_reg, r1_reg;
    logic [CW-1:0]    c0, c1, c0_reg, c1_reg;
    logic [SW-1:0]    slot0;
    logic [31:0]      tmp_r1, tmp_c1, back32, slot32;

    always_comb
    begin
        r0     = (erow_reg >= ROW_W'(lat_hy_reg)) ? erow_reg - ROW_W'(lat_hy_reg) : '0;
        tmp_r1 = 32'(erow_reg) + 32'(lat_hy_reg);
        if (tmp_r1 > 32'(lat_h_reg) - 32'd1)
            tmp_r1 = 32'(lat_h_reg) - 32'd1;
        r1     = tmp_r1[ROW_W-1:0];
        c0     = (32'(ecol_reg) >= 32'(lat_hx_reg)) ? CW'(32'(ecol_reg) - 32'(lat_hx_reg)) : '0;
        tmp_c1 = 32'(ecol_reg) + 32'(lat_hx_reg);
        if (tmp_c1 > 32'(lat_w_reg) - 32'd1)
            tmp_c1 = 32'(lat_w_reg) - 32'd1;
        c1     = tmp_c1[CW-1:0];
        back32 = 32'(erow_reg - r0);
        slot32 = (32'(eslot_reg) >= back32) ? 32'(eslot_reg) - back32
                                            : 32'(eslot_reg) + 32'(SR) - back32;
        slot0  = slot32[SW-1:0];
    end

    // ---- scan front end: offsets registered beside the store read
    logic          v0_reg;
    logic [OW-1:0] di0_reg, dj0_reg;
    logic [31:0]   di32, dj32;
    logic [2:0]    drain_reg;

    assign di32 = (scan_c_reg > ecol_reg) ? 32'(scan_c_reg - ecol_reg)
                                          : 32'(ecol_reg - scan_c_reg);
    assign dj32 = (scan_r_reg > erow_reg) ? 32'(scan_r_reg - erow_reg)
                                          : 32'(erow_reg - scan_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= (state_reg == S_SCAN);
    end

    always_ff @(posedge clk)
    begin
        di0_reg <= di32[OW-1:0];
        dj0_reg <= dj32[OW-1:0];
    end

    // ---- chain of distance cells: x term, then y term added
    logic          vx, vy;
    logic [OW-1:0] djx;
    logic [AW-1:0] accx, accy;

    metap_cell #(.OW(OW), .AW(AW)) u_cell_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v0_reg && np_q_reg),
        .offset   (di0_reg),
        .pitch    (lat_px_reg),
        .aux_in   (dj0_reg),
        .acc_in   ('0),
        .out_valid(vx),
        .aux_out  (djx),
        .acc_out  (accx)
    );

    metap_cell #(.OW(OW), .AW(AW)) u_cell_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vx),
        .offset   (djx),
        .pitch    (lat_py_reg),
        .aux_in   ('0),
        .acc_in   (accx),
        .out_valid(vy),
        .aux_out  (),
        .acc_out  (accy)
    );

    // nearest distance, saturated to 32 bits
    logic [31:0] min_reg;
    logic [31:0] d_sat;
    assign d_sat = (accy[AW-1:32] != '0) ? 32'hFFFF_FFFF : accy[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= 32'hFFFF_FFFF;
        else if (state_reg == S_CHECK)
            min_reg <= 32'hFFFF_FFFF;
        else if (vy && (d_sat < min_reg))
            min_reg <= d_sat;
    end

    // ---- taper table and scaling
    logic [15:0] rom_q_reg;
    logic        taper_reg;
    logic [31:0] prod_reg;
    logic        val_pos;
    logic        out_load;

    assign val_pos  = !val_q_reg[15] && (val_q_reg != 16'sd0);
    assign out_load = (state_reg == S_DONE) && (!m_tvalid || m_tready);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROM)
            rom_q_reg <= (lat_mode_reg == MODE_C1) ? ROM_C1[min_reg[23 -: LG]]
                                                   : ROM_C2[min_reg[23 -: LG]];
        if (state_reg == S_MUL)
            prod_reg <= {17'b0, val_q_reg[14:0]} * {16'b0, rom_q_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            taper_reg <= 1'b0;
        else if (state_reg == S_CHECK)
            taper_reg <= 1'b0;
        else if (state_reg == S_ROM)
            taper_reg <= ({1'b0, min_reg} < ONE_Q24);
    end

    // ---- control state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (emit) state_next = S_FETCH;
            S_FETCH: state_next = S_CHECK;
            S_CHECK: state_next = ((lat_mode_reg == MODE_C1 || lat_mode_reg == MODE_C2)
                                   && val_pos) ? S_SCAN : S_DONE;
            S_SCAN:  if (scan_c_reg == c1_reg && scan_r_reg == r1_reg) state_next = S_DRAIN;
            S_DRAIN: if (drain_reg == 3'd0) state_next = S_ROM;
            S_ROM:   state_next = S_MUL;
            S_MUL:   state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_r_reg    <= '0;
            scan_c_reg    <= '0;
            scan_slot_reg <= '0;
            r1_reg        <= '0;
            c0_reg        <= '0;
            c1_reg        <= '0;
            drain_reg     <= '0;
        end
        else if (state_reg == S_CHECK)
        begin
            scan_r_reg    <= r0;
            scan_c_reg    <= c0;
            scan_slot_reg <= slot0;
            r1_reg        <= r1;
            c0_reg        <= c0;
            c1_reg        <= c1;
        end
        else if (state_reg == S_SCAN)
        begin
            drain_reg <= 3'(DRAIN_CYCLES - 1);
            if (scan_c_reg == c1_reg)
            begin
                scan_c_reg <= c0_reg;
                if (scan_r_reg != r1_reg)
                begin
                    scan_r_reg    <= scan_r_reg + 1'b1;
                    scan_slot_reg <= (32'(scan_slot_reg) == SR - 1) ? '0
                                                                    : scan_slot_reg + 1'b1;
                end
            end
            else
                scan_c_reg <= scan_c_reg + 1'b1;
        end
        else if (state_reg == S_DRAIN)
            drain_reg <= drain_reg - 1'b1;
    end

    // frame settings and stream position
    logic frame_end;
    assign frame_end = (32'(ecol_reg) + 32'd1 >= 32'(lat_w_reg))
                       && (32'(erow_reg) + 32'd1 >= 32'(lat_h_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_mode_reg  <= 2'd0;
            lat_w_reg     <= WW'(MAX_WIDTH);
            lat_h_reg     <= ROW_W'(MAX_HEIGHT);
            lat_px_reg    <= 16'd4096;
            lat_py_reg    <= 16'd4096;
            lat_hx_reg    <= OW'(1);
            lat_hy_reg    <= OW'(1);
            lat_delay_reg <= PW'(MAX_WIDTH + 1);
            wcol_reg      <= '0;
            wrow_reg      <= '0;
            wslot_reg     <= '0;
            ecol_reg      <= '0;
            erow_reg      <= '0;
            eslot_reg     <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            if (latch_now)
            begin
                lat_mode_reg  <= taper_mode_reg;
                lat_w_reg     <= new_w;
                lat_h_reg     <= new_h;
                lat_px_reg    <= pitch_x_reg;
                lat_py_reg    <= pitch_y_reg;
                lat_hx_reg    <= new_hx;
                lat_hy_reg    <= new_hy;
                lat_delay_reg <= new_delay;
            end
            if (do_write)
            begin
                pend_reg <= pend_reg + 1'b1;
                if (wcol_inc >= 32'(eff_w))
                begin
                    wcol_reg  <= '0;
                    wrow_reg  <= wrow_reg + 1'b1;
                    wslot_reg <= (32'(wslot_reg) == SR - 1) ? '0 : wslot_reg + 1'b1;
                end
                else
                    wcol_reg <= wcol_inc[CW-1:0];
            end
            if (out_load)
            begin
                pend_reg <= pend_reg - 1'b1;
                if (frame_end)
                begin
                    // last pixel of the frame: back to the start
                    ecol_reg  <= '0;
                    erow_reg  <= '0;
                    eslot_reg <= '0;
                    wcol_reg  <= '0;
                    wrow_reg  <= '0;
                    wslot_reg <= '0;
                end
                else if (32'(ecol_reg) + 32'd1 >= 32'(lat_w_reg))
                begin
                    ecol_reg  <= '0;
                    erow_reg  <= erow_reg + 1'b1;
                    eslot_reg <= (32'(eslot_reg) == SR - 1) ? '0 : eslot_reg + 1'b1;
                end
                else
                    ecol_reg <= ecol_reg + 1'b1;
            end
        end
    end

    // ---- output register
    logic        out_valid_reg;
    logic [15:0] out_val_reg;
    logic [9:0]  out_col_reg, out_row_reg;
    logic        out_last_reg;
    logic [31:0] ecol32, erow32;

    assign ecol32 = 32'(ecol_reg);
    assign erow32 = 32'(erow_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_val_reg  <= taper_reg ? prod_reg[30:15] : val_q_reg;
            out_col_reg  <= ecol32[9:0];
            out_row_reg  <= erow32[9:0];
            out_last_reg <= frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_row_reg, out_col_reg, out_val_reg};
    assign m_tlast  = out_last_reg;

    // ---- checks
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pend_reg) <= 32'(lat_delay_reg) + 32'd1)
        else $error("pending pixel count beyond the delay");

    a_scan_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_r_reg <= r1_reg && scan_c_reg <= c1_reg))
        else $error("window scan outside its bounds");

    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == '0) |-> (ecol_reg == wcol_reg && erow_reg == wrow_reg))
        else $error("emit position differs from write position with nothing pending");

    a_emit_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (pend_reg != '0))
        else $error("pixel emitted with nothing pending");

endmodule

// ===== tb/mask_edge_taper_apodizer_tb.sv =====
// Self-checking testbench for the mask edge taper: frame streams against a cycle-free predictor.
`timescale 1ns / 1ps

module mask_edge_taper_apodizer_tb;
    import metap_pkg::*;

    localparam int  ROWS_HELD   = 18;       // 2*MAX_HALF_WINDOW+2 row slots
    localparam int  WMAX        = 1024;
    localparam int  HALF_MAX    = 8;
    localparam int  SETTLE      = 400;      // idle pause, longer than the worst item
    localparam int  LIMIT       = 4000000;
    localparam int  ITEM_TARGET = 1850;     // includes the wide frame of about 1024 items

    typedef struct packed {
        logic [15:0] val;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
    } pix_t;

    typedef struct {
        logic [15:0] val;
        logic        flush;
        logic        known;     // typed-in result replaces the prediction
        pix_t        res;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    mask_edge_taper_apodizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor state: row stores, counters, registers and frame latches
    // ------------------------------------------------------------------
    logic [15:0] value_rows [ROWS_HELD][WMAX];
    bit          neg_rows   [ROWS_HELD][WMAX];
    logic [15:0] taper_tab  [2][1024];
    int unsigned wr_col, wr_row, em_col, em_row;
    int unsigned reg_mode, reg_w, reg_h, reg_px, reg_py, reg_hx, reg_hy;
    int unsigned f_mode, f_w, f_h, f_px, f_py, f_hx, f_hy;

    item_t stim_q[$];
    pix_t  pixel_q[$];       // predicted output pixels, oldest first
    item_t cur;
    bit    took;
    bit    quiet;
    int    gap_s, gap_m;
    int    pushed, accepted, got, errors, cyc, frames;

    // square root by bit pairs
    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'h1 << 62;
        while (bt > n)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n   = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // quarter-wave Taylor series, Q.30
    function automatic longint quarter_sine(longint unsigned phi);
        longint unsigned p2;
        longint unsigned term;
        longint          sum;
        p2   = (phi * phi) >> 30;
        term = phi;
        sum  = longint'(phi);
        for (int n = 1; n <= 9; n++)
        begin
            term = ((term * p2) >> 30) / longint'((2 * n) * (2 * n + 1));
            sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'd1073741824)
            sum = 64'd1073741824;
        return sum;
    endfunction

    // angle in 2^-24 turns
    function automatic longint turn_sine(logic [31:0] t);
        logic [23:0] tt;
        logic [31:0] r;
        longint      s;
        tt = t[23:0];
        r  = {10'd0, tt[21:0]};
        if (tt[22])
            r = 32'h40_0000 - r;
        s = quarter_sine((longint'(r) * 64'd6746518852) >> 24);
        return tt[23] ? -s : s;
    endfunction

    function automatic logic [15:0] clamp_q15(longint f);
        longint g;
        g = f < 0 ? 0 : f;
        if (g > 64'd1073741824)
            g = 64'd1073741824;
        return 16'(g >> 15);
    endfunction

    function automatic void fill_taper_tab();
        logic [31:0]     x24;
        longint          x30;
        longint          s;
        longint          c;
        longint          mag;
        longint unsigned s_abs;
        for (int k = 0; k < 1024; k++)
        begin
            x24   = 32'(root64(longint'(k) << 38));
            x30   = longint'(x24) <<< 6;
            s     = turn_sine(x24);
            s_abs = s < 0 ? -s : s;
            mag   = longint'((s_abs << 30) / 64'd6746518852);
            c     = turn_sine((x24 >> 1) + 32'h40_0000);
            taper_tab[0][k] = clamp_q15(s >= 0 ? x30 - mag : x30 + mag);
            taper_tab[1][k] = clamp_q15((64'd1073741824 - c) >>> 1);
        end
    endfunction

    function automatic void latch_frame();
        f_mode = reg_mode;
        f_w    = reg_w == 0 ? 1 : (reg_w > WMAX ? WMAX : reg_w);
        f_h    = reg_h == 0 ? 1 : (reg_h > MAX_HEIGHT ? MAX_HEIGHT : reg_h);
        f_px   = reg_px;
        f_py   = reg_py;
        f_hx   = reg_hx > HALF_MAX ? HALF_MAX : reg_hx;
        f_hy   = reg_hy > HALF_MAX ? HALF_MAX : reg_hy;
        if (f_hx > f_w - 1)
            f_hx = f_w - 1;
        if (f_hy > f_h - 1)
            f_hy = f_h - 1;
    endfunction

    // pixel leaving the delay line, tapered by nearest non-positive neighbor
    function automatic pix_t taper_pixel();
        pix_t            p;
        longint          v;
        longint unsigned d2;
        longint unsigned nearest;
        longint unsigned di;
        longint unsigned dj;
        int unsigned     r0, r1, c0, c1;
        v = longint'($signed(value_rows[em_row % ROWS_HELD][em_col]));
        if ((f_mode == MODE_C1 || f_mode == MODE_C2) && v > 0)
        begin
            r0 = em_row >= f_hy ? em_row - f_hy : 0;
            r1 = em_row + f_hy < f_h - 1 ? em_row + f_hy : f_h - 1;
            c0 = em_col >= f_hx ? em_col - f_hx : 0;
            c1 = em_col + f_hx < f_w - 1 ? em_col + f_hx : f_w - 1;
            nearest = 64'hFFFF_FFFF;
            for (int unsigned r = r0; r <= r1; r++)
                for (int unsigned c = c0; c <= c1; c++)
                    if (neg_rows[r % ROWS_HELD][c])
                    begin
                        di = longint'(c > em_col ? c - em_col : em_col - c) * f_px;
                        dj = longint'(r > em_row ? r - em_row : em_row - r) * f_py;
                        d2 = di * di + dj * dj;
                        if (d2 > 64'hFFFF_FFFF)
                            d2 = 64'hFFFF_FFFF;
                        if (d2 < nearest)
                            nearest = d2;
                    end
            if (nearest < 64'd16777216)
                v = (v * longint'(taper_tab[f_mode - 1][nearest >> 14])) >>> 15;
        end
        p.val  = 16'(v);
        p.col  = 10'(em_col);
        p.row  = 10'(em_row);
        em_col++;
        if (em_col >= f_w)
        begin
            em_col = 0;
            em_row++;
        end
        p.last = em_row >= f_h;
        if (p.last)
        begin
            em_col = 0;
            em_row = 0;
            wr_col = 0;
            wr_row = 0;
        end
        return p;
    endfunction

    // one accepted item; returns 1 and the pixel when it releases one
    function automatic bit step_pixel(item_t it, output pix_t p);
        bit          idle;
        bit          drained;
        int unsigned slot;
        longint      written;
        longint      emitted;
        idle = wr_row == 0 && wr_col == 0;
        if (idle && !it.flush)
            latch_frame();
        drained = !idle && wr_row >= f_h;
        if (!it.flush && !drained)
        begin
            slot = wr_row % ROWS_HELD;
            value_rows[slot][wr_col] = it.val;
            neg_rows[slot][wr_col]   = it.val == 0 || it.val[15];
            wr_col++;
            if (wr_col >= f_w)
            begin
                wr_col = 0;
                wr_row++;
            end
            written = longint'(wr_row) * f_w + wr_col;
            emitted = longint'(em_row) * f_w + em_col;
            if (written - emitted > longint'(f_hy) * f_w + f_hx)
            begin
                p = taper_pixel();
                return 1;
            end
            return 0;
        end
        if (drained)
        begin
            p = taper_pixel();
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Sender: items change at the falling edge, taken at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_t p;
        if (rst_n && s_tvalid && s_tready)
        begin
            took = 1'b1;
            accepted++;
            if (step_pixel(cur, p))
                pixel_q.push_back(cur.known ? cur.res : p);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !took))
        begin
            took = 1'b0;
            if (gap_s > 0)
            begin
                gap_s--;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                gap_s = $urandom_range(1, 13) - 1;
                s_tvalid <= 1'b0;
            end
            else if (stim_q.size() > 0)
            begin
                cur = stim_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur.val;
                s_tuser  <= cur.flush;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, field by field compare
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (gap_m > 0)
            begin
                gap_m--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                gap_m = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pix_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            got++;
            if (pixel_q.size() == 0)
            begin
                $error("unexpected pixel col=%0d row=%0d", m_tdata[25:16], m_tdata[35:26]);
                errors++;
            end
            else
            begin
                e = pixel_q.pop_front();
                if (m_tdata[15:0] !== e.val)
                begin
                    $error("apodized_value expected %h got %h", e.val, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[25:16] !== e.col)
                begin
                    $error("pixel_column expected %0d got %0d", e.col, m_tdata[25:16]);
                    errors++;
                end
                if (m_tdata[35:26] !== e.row)
                begin
                    $error("pixel_row expected %0d got %0d", e.row, m_tdata[35:26]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_of_frame expected %0b got %0b", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t mk(logic [15:0] v, logic f, logic k, logic [15:0] ev,
                                 int ec, int er, logic el);
        item_t it;
        it.val   = v;
        it.flush = f;
        it.known = k;
        it.res   = '{ev, 10'(ec), 10'(er), el};
        return it;
    endfunction

    function automatic logic [15:0] rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return {1'b1, 15'($urandom)};
        if (r < 30)
            return 16'd0;
        if (r < 40)
            return 16'($urandom);
        return 16'($urandom_range(1, 32767));
    endfunction

    task automatic put_reg(logic [2:0] idx, int unsigned v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(v);
        case (idx)
            REG_TAPER_MODE:   reg_mode = v & 32'h3;
            REG_FRAME_WIDTH:  reg_w    = v & 32'h7FF;
            REG_FRAME_HEIGHT: reg_h    = v & 32'h7FF;
            REG_PITCH_X:      reg_px   = v & 32'hFFFF;
            REG_PITCH_Y:      reg_py   = v & 32'hFFFF;
            REG_HALF_X:       reg_hx   = v & 32'hF;
            REG_HALF_Y:       reg_hy   = v & 32'hF;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // block idle: every item taken, every pixel out, then the latency pause
    task automatic wait_idle();
        do
            @(negedge clk);
        while (accepted != pushed || pixel_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic push(item_t it);
        stim_q.push_back(it);
        pushed++;
    endtask

    // one full frame with random content, mid-frame noise flushes, then the drain
    task automatic queue_frame();
        int unsigned pixels;
        int unsigned held;
        latch_frame();
        pixels = f_w * f_h;
        held   = f_hy * f_w + f_hx;
        for (int unsigned n = 0; n < pixels; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                push(mk(16'($urandom), 1'b1, 1'b0, 16'd0, 0, 0, 1'b0));
            push(mk(rand_pixel(), 1'b0, 1'b0, 16'd0, 0, 0, 1'b0));
        end
        // a data item during the drain counts as a flush
        for (int unsigned n = 0; n < held; n++)
            push(mk(16'($urandom), $urandom_range(0, 7) != 0, 1'b0, 16'd0, 0, 0, 1'b0));
        repeat ($urandom_range(0, 2))
            push(mk(16'($urandom), 1'b1, 1'b0, 16'd0, 0, 0, 1'b0));
        frames++;
    endtask

    int unsigned pick_half;

    initial
    begin
        item_t dir_tab[12];
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        took      = 1'b0;
        quiet     = 1'b0;
        gap_s     = 0;
        gap_m     = 0;
        pushed    = 0;
        accepted  = 0;
        got       = 0;
        errors    = 0;
        cyc       = 0;
        frames    = 0;
        wr_col = 0; wr_row = 0; em_col = 0; em_row = 0;
        reg_mode = 0; reg_w = 1024; reg_h = 1024;
        reg_px = 4096; reg_py = 4096; reg_hx = 1; reg_hy = 1;
        latch_frame();
        fill_taper_tab();

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: 3x2 pass-through frame, 3x3 window, delay of 4 pixels.
        // Covers value extremes, a flush mid frame, a data item during the
        // drain, last_of_frame, and a flush while idle.
        put_reg(REG_TAPER_MODE, 0);
        put_reg(REG_FRAME_WIDTH, 3);
        put_reg(REG_FRAME_HEIGHT, 2);
        put_reg(REG_PITCH_X, 4096);
        put_reg(REG_PITCH_Y, 4096);
        put_reg(REG_HALF_X, 1);
        put_reg(REG_HALF_Y, 1);
        end_writes();
        dir_tab[0]  = mk(16'h7FFF, 1'b0, 1'b0, 16'h0000, 0, 0, 1'b0);
        dir_tab[1]  = mk(16'h8000, 1'b0, 1'b0, 16'h0000, 0, 0, 1'b0);
        dir_tab[2]  = mk(16'hA5A5, 1'b1, 1'b0, 16'h0000, 0, 0, 1'b0);
        dir_tab[3]  = mk(16'h0000, 1'b0, 1'b0, 16'h0000, 0, 0, 1'b0);
        dir_tab[4]  = mk(16'h0001, 1'b0, 1'b0, 16'h0000, 0, 0, 1'b0);
        dir_tab[5]  = mk(16'hFFFF, 1'b0, 1'b1, 16'h7FFF, 0, 0, 1'b0);
        dir_tab[6]  = mk(16'h0064, 1'b0, 1'b1, 16'h8000, 1, 0, 1'b0);
        dir_tab[7]  = mk(16'h0000, 1'b1, 1'b1, 16'h0000, 2, 0, 1'b0);
        dir_tab[8]  = mk(16'h1234, 1'b0, 1'b1, 16'h0001, 0, 1, 1'b0);
        dir_tab[9]  = mk(16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1, 1, 1'b0);
        dir_tab[10] = mk(16'h0000, 1'b1, 1'b1, 16'h0064, 2, 1, 1'b1);
        dir_tab[11] = mk(16'h5555, 1'b1, 1'b0, 16'h0000, 0, 0, 1'b0);
        foreach (dir_tab[n])
            push(dir_tab[n]);
        frames++;
        wait_idle();

        // Settings phases: random small frames, with extremes in the early phases
        for (int ph = 0; pushed < ITEM_TARGET; ph++)
        begin
            if (pushed > ITEM_TARGET - 150)
                quiet = 1'b1;
            put_reg(REG_TAPER_MODE, ph < 2 ? ph + 1 : $urandom_range(0, 3));
            put_reg(REG_FRAME_WIDTH, $urandom_range(1, 16));
            put_reg(REG_FRAME_HEIGHT, $urandom_range(1, 6));
            if (ph < 2 || $urandom_range(0, 2) != 0)
            begin
                put_reg(REG_PITCH_X, $urandom_range(512, 6144));
                put_reg(REG_PITCH_Y, $urandom_range(512, 6144));
            end
            if ($urandom_range(0, 2) != 0)
            begin
                pick_half = $urandom_range(0, 7) == 0 ? 8 : $urandom_range(0, 3);
                put_reg(REG_HALF_X, pick_half);
                put_reg(REG_HALF_Y, $urandom_range(0, 3));
            end
            case (ph)
                2: put_reg(REG_TAPER_MODE, 3);
                3: put_reg(REG_FRAME_WIDTH, 0);
                4: put_reg(REG_FRAME_HEIGHT, 0);
                5:
                begin
                    put_reg(REG_FRAME_WIDTH, 16);
                    put_reg(REG_FRAME_HEIGHT, 6);
                    put_reg(REG_HALF_X, 15);
                    put_reg(REG_HALF_Y, 15);
                    put_reg(REG_TAPER_MODE, 2);
                end
                6:
                begin
                    put_reg(REG_TAPER_MODE, 1);
                    put_reg(REG_PITCH_X, 0);
                    put_reg(REG_PITCH_Y, 65535);
                end
                7:
                begin
                    put_reg(REG_TAPER_MODE, 2);
                    put_reg(REG_PITCH_X, 65535);
                    put_reg(REG_PITCH_Y, 0);
                end
                8:
                begin
                    // widest row saturates at MAX_WIDTH, all column bits toggle
                    put_reg(REG_TAPER_MODE, 1);
                    put_reg(REG_FRAME_WIDTH, 2047);
                    put_reg(REG_FRAME_HEIGHT, 1);
                    put_reg(REG_PITCH_X, 2048);
                    put_reg(REG_HALF_X, 8);
                end
                default: ;
            endcase
            end_writes();
            queue_frame();
            wait_idle();
        end

        $display("Covered %0d frames, %0d items in, %0d pixels out", frames, pushed, got);
        $display("Modes pass/C1/C2/3, geometry and window extremes, drains and flushes");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/metap_pkg.sv
hdl/metap_cell.sv
hdl/mask_edge_taper_apodizer.sv
tb/mask_edge_taper_apodizer_tb.sv
